// ----- hdl/packbits_line_decode_interleave_macros.svh -----
// Assertion macros used by the PackBits line decoder sequencer.
`ifndef PACKBITS_LINE_DECODE_INTERLEAVE_MACROS_SVH
`define PACKBITS_LINE_DECODE_INTERLEAVE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PLD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PLD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pld_pkg.sv -----
// Types and constants of the PackBits line decoder.
`timescale 1ns / 1ps

package pld_pkg;

  // Resolution mode codes
  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_MED  = 2'd1;
  localparam logic [1:0] MODE_MONO = 2'd2;

  // Decoder phase codes
  localparam logic [1:0] PHASE_CONTROL = 2'd0;
  localparam logic [1:0] PHASE_LITERAL = 2'd1;
  localparam logic [1:0] PHASE_REPEAT  = 2'd2;

  // Line geometry
  localparam logic [7:0] LINE_LEN_FULL = 8'd160;
  localparam logic [7:0] LINE_LEN_MONO = 8'd80;
  localparam logic [5:0] LAST_PAIR_FULL = 6'd39;
  localparam logic [5:0] LAST_PAIR_MONO = 6'd19;
  localparam logic [6:0] STRIDE_FOUR_PLANE = 7'd20;
  localparam logic [6:0] STRIDE_TWO_PLANE  = 7'd40;

  // Control byte that does nothing
  localparam logic [7:0] CTRL_NOP = 8'h80;

  // One emitted word pair
  typedef struct packed {
    logic [5:0]  pair_index;
    logic [31:0] word_pair;
    logic        last_of_line;
    logic        overrun;
  } pair_t;

  // Plane base word for four-plane interleave: 0, 20, 40, 60
  function automatic logic [6:0] plane_base4(input logic [1:0] plane);
    logic [6:0] base;
    base = 7'd0;
    case (plane)
      2'd0: base = 7'd0;
      2'd1: base = STRIDE_FOUR_PLANE;
      2'd2: base = 7'd40;
      default: base = 7'd60;
    endcase
    return base;
  endfunction

endpackage

// ----- hdl/pld_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/pld_obuf.sv -----
// One-entry output register for emitted word pairs.
`timescale 1ns / 1ps

module pld_obuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pld_pkg::pair_t din,
  output logic           ready,
  output logic           valid,
  input  logic           take,
  output pld_pkg::pair_t dout
);

  // Accept a new pair when empty or when the held one leaves this cycle
  assign ready = !valid || take;

  // Hold valid until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (push) begin
      dout <= din;
    end
  end

endmodule

// ----- hdl/pld_seq.sv -----
// Decode sequencer: run expansion into the line store and interleaved readout.
`timescale 1ns / 1ps

module pld_seq #(
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              push,
  input  logic              obuf_ready,
  output pld_pkg::pair_t    pair_out
);

  `include "packbits_line_decode_interleave_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0]  state, state_next;
  logic [1:0]  phase, phase_next;
  logic [7:0]  fill, fill_next;
  logic [7:0]  run, run_next;
  logic        spilled, spilled_next;
  logic [7:0]  value, value_next;
  logic        ctrl_pending, ctrl_pending_next;
  logic [5:0]  pair, pair_next;
  logic [2:0]  rd_k, rd_k_next;
  logic [31:0] word, word_next;

  logic [7:0]  len;
  logic [5:0]  pairs_last;
  logic        full_mode;
  logic [7:0]  parse_src;
  logic [7:0]  parse_run;
  logic [1:0]  parse_phase;
  logic [6:0]  out_word;
  logic [6:0]  src_word;

  // Line geometry from the mode; code three acts as monochrome
  assign full_mode  = (mode == pld_pkg::MODE_LOW) || (mode == pld_pkg::MODE_MED);
  assign len        = full_mode ? pld_pkg::LINE_LEN_FULL : pld_pkg::LINE_LEN_MONO;
  assign pairs_last = full_mode ? pld_pkg::LAST_PAIR_FULL : pld_pkg::LAST_PAIR_MONO;

  // Control byte decode: literal n+1, repeat 257-n, no-op
  assign parse_src = ctrl_pending ? value : in_byte;
  always_comb begin
    parse_run   = 8'd0;
    parse_phase = pld_pkg::PHASE_CONTROL;
    if (!parse_src[7]) begin
      parse_run   = parse_src + 8'd1;
      parse_phase = pld_pkg::PHASE_LITERAL;
    end else if (parse_src != pld_pkg::CTRL_NOP) begin
      parse_run   = (~parse_src) + 8'd2;
      parse_phase = pld_pkg::PHASE_REPEAT;
    end
  end

  // Map output word to plane-sequential source word
  assign out_word = {pair, rd_k[1]};
  always_comb begin
    if (mode == pld_pkg::MODE_LOW) begin
      src_word = pld_pkg::plane_base4(out_word[1:0]) + {2'b00, out_word[6:2]};
    end else if (mode == pld_pkg::MODE_MED) begin
      src_word = (out_word[0] ? pld_pkg::STRIDE_TWO_PLANE : 7'd0)
               + {1'b0, out_word[6:1]};
    end else begin
      src_word = out_word;
    end
  end
  assign ram_raddr = ADDR_W'({src_word, rd_k[0]});

  assign in_ready  = (state == S_IDLE);
  assign ram_waddr = ADDR_W'(fill);
  assign ram_wdata = (state == S_FILL) ? value : in_byte;

  assign pair_out.pair_index   = pair;
  assign pair_out.word_pair    = word;
  assign pair_out.last_of_line = (pair == pairs_last);
  assign pair_out.overrun      = spilled;

  // Sequence decode, fill and readout
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    fill_next         = fill;
    run_next          = run;
    spilled_next      = spilled;
    value_next        = value;
    ctrl_pending_next = ctrl_pending;
    pair_next         = pair;
    rd_k_next         = rd_k;
    word_next         = word;
    ram_we            = 1'b0;
    push              = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (phase)
            pld_pkg::PHASE_LITERAL: begin
              if (fill < len) begin
                ram_we    = 1'b1;
                fill_next = fill + 8'd1;
              end else begin
                spilled_next = 1'b1;
                if (fill > len) begin
                  fill_next = len;
                end
              end
              if (run != 8'd0) begin
                run_next = run - 8'd1;
              end
              if (run <= 8'd1) begin
                phase_next = pld_pkg::PHASE_CONTROL;
                state_next = S_CHECK;
              end
            end
            pld_pkg::PHASE_REPEAT: begin
              value_next = in_byte;
              state_next = S_FILL;
            end
            default: begin
              if (fill >= len) begin
                value_next        = in_byte;
                ctrl_pending_next = 1'b1;
                pair_next         = 6'd0;
                rd_k_next         = 3'd0;
                state_next        = S_EMIT;
              end else begin
                run_next   = parse_run;
                phase_next = parse_phase;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        if (run == 8'd0) begin
          phase_next = pld_pkg::PHASE_CONTROL;
          state_next = S_CHECK;
        end else if (fill < len) begin
          ram_we    = 1'b1;
          fill_next = fill + 8'd1;
          run_next  = run - 8'd1;
        end else begin
          // drop the rest of the run past the line end
          spilled_next = 1'b1;
          run_next     = 8'd0;
          if (fill > len) begin
            fill_next = len;
          end
        end
      end
      S_CHECK: begin
        if (fill >= len) begin
          ctrl_pending_next = 1'b0;
          pair_next         = 6'd0;
          rd_k_next         = 3'd0;
          state_next        = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        // issue four byte reads, shift each one in on the cycle after its read
        if (rd_k != 3'd0) begin
          word_next = {word[23:0], ram_rdata};
        end
        rd_k_next = rd_k + 3'd1;
        if (rd_k == 3'd4) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (obuf_ready) begin
          push = 1'b1;
          if (pair == pairs_last) begin
            fill_next         = 8'd0;
            spilled_next      = 1'b0;
            phase_next        = pld_pkg::PHASE_CONTROL;
            run_next          = 8'd0;
            ctrl_pending_next = 1'b0;
            state_next        = S_IDLE;
            if (ctrl_pending) begin
              run_next   = parse_run;
              phase_next = parse_phase;
            end
          end else begin
            pair_next  = pair + 6'd1;
            rd_k_next  = 3'd0;
            state_next = S_EMIT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= pld_pkg::PHASE_CONTROL;
      fill         <= 8'd0;
      run          <= 8'd0;
      spilled      <= 1'b0;
      ctrl_pending <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      fill         <= fill_next;
      run          <= run_next;
      spilled      <= spilled_next;
      ctrl_pending <= ctrl_pending_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value <= value_next;
    pair  <= pair_next;
    rd_k  <= rd_k_next;
    word  <= word_next;
  end

  `PLD_ASSERT_IMP(a_write_in_line, ram_we, fill < len, "store write past line end")
  `PLD_ASSERT_IMP(a_control_no_run, phase == pld_pkg::PHASE_CONTROL, run == 8'd0,
                  "run count left while expecting a control byte")
  `PLD_ASSERT_IMP(a_pending_in_emit, ctrl_pending, (state == S_EMIT) || (state == S_PUSH),
                  "held control byte outside line emission")
  `PLD_ASSERT_NXT(a_line_clears, push && (pair == pairs_last), (fill == 8'd0) && !spilled,
                  "line state not cleared after last pair")

endmodule

// ----- hdl/packbits_line_decode_interleave.sv -----
// Decoding: each literal byte is stored as it arrives, and the byte that closes a run is
// followed by a line-end check; a repeat run takes its value byte, then writes it into the store.
// Line emission reads the line store one byte a cycle, four reads per pair, and each
// pair then waits in a push state until the output register can take it.
// Throughput: one compressed byte at a time; ready only while the sequencer is idle.
// Reset (rst, synchronous) clears the decoder state and sets mode 1; no store clearing.
`timescale 1ns / 1ps

module packbits_line_decode_interleave #(
  parameter int LINE_STORE_BYTES = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,      // resolution_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [5:0] pair_index, [37:6] word_pair, [39:38] zero
  output logic        m_axis_tlast,   // last_of_line
  output logic        m_axis_tuser    // overrun
);

  localparam int ADDR_W = $clog2(LINE_STORE_BYTES);

  logic [1:0]        resolution_mode;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              push;
  logic              obuf_ready;
  pld_pkg::pair_t    pair_seq;
  pld_pkg::pair_t    pair_out;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_mode <= pld_pkg::MODE_MED;
    end else if (cfg_we) begin
      resolution_mode <= cfg_wdata;
    end
  end

  pld_seq #(
    .ADDR_W(ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .mode      (resolution_mode),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .push      (push),
    .obuf_ready(obuf_ready),
    .pair_out  (pair_seq)
  );

  pld_ram #(
    .WIDTH(8),
    .DEPTH(LINE_STORE_BYTES)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pld_obuf u_obuf (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (pair_seq),
    .ready(obuf_ready),
    .valid(m_axis_tvalid),
    .take (m_axis_tready),
    .dout (pair_out)
  );

  // Pack result fields
  assign m_axis_tdata = {2'b00, pair_out.word_pair, pair_out.pair_index};
  assign m_axis_tlast = pair_out.last_of_line;
  assign m_axis_tuser = pair_out.overrun;

endmodule
